### rtl/indexed_min_heap_assert.svh
`ifndef INDEXED_MIN_HEAP_ASSERT_SVH
`define INDEXED_MIN_HEAP_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define IMH_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define IMH_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### rtl/imh_pkg.sv
package imh_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int KEY_BITS_DEF = 64;
    localparam int NUM_HANDLES  = 256;
    localparam int HANDLE_W     = 8;
    localparam int KEY_W        = 64;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 9;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_POP    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd4;

    localparam logic [2:0] HR_ZERO  = 3'd0;
    localparam logic [2:0] HR_CNTM1 = 3'd1;
    localparam logic [2:0] HR_UP    = 3'd2;
    localparam logic [2:0] HR_LEFT  = 3'd3;
    localparam logic [2:0] HR_RIGHT = 3'd4;

    typedef struct packed {
        logic                ld_in;
        logic                hr_en;
        logic [2:0]          hr_sel;
        logic                st_en;
        logic [STATUS_W-1:0] st_val;
        logic                ins_start;
        logic                rm_start;
        logic                pop_take;
        logic                ld_m;
        logic                dn_left;
        logic                dn_right;
        logic                dn_step;
        logic                up_step;
        logic                place;
        logic                emit;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            present;
        logic            full;
        logic            empty;
        logic            rm_bad;
        logic            rm_last;
        logic            cnt_one;
        logic            l_ok;
        logic            r_ok;
        logic            best_same;
        logic            at_start;
        logic            at_root;
        logic            up_lt;
        logic            out_free;
    } t_stat;

endpackage

### rtl/imh_ctrl.sv
module imh_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  imh_pkg::t_stat i_stat,
    output imh_pkg::t_cmd  o_cmd
);
    import imh_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DEC    = 5'd1;
    localparam logic [4:0] S_RM_P   = 5'd2;
    localparam logic [4:0] S_POP_H  = 5'd3;
    localparam logic [4:0] S_POP_K  = 5'd4;
    localparam logic [4:0] S_LAST_H = 5'd5;
    localparam logic [4:0] S_LAST_K = 5'd6;
    localparam logic [4:0] S_DN_L   = 5'd7;
    localparam logic [4:0] S_DN_LH  = 5'd8;
    localparam logic [4:0] S_DN_LK  = 5'd9;
    localparam logic [4:0] S_DN_RH  = 5'd10;
    localparam logic [4:0] S_DN_RK  = 5'd11;
    localparam logic [4:0] S_DN_DEC = 5'd12;
    localparam logic [4:0] S_DN_END = 5'd13;
    localparam logic [4:0] S_UP_CHK = 5'd14;
    localparam logic [4:0] S_UP_H   = 5'd15;
    localparam logic [4:0] S_UP_K   = 5'd16;
    localparam logic [4:0] S_PLACE  = 5'd17;
    localparam logic [4:0] S_RES    = 5'd18;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.present) begin
                            o_cmd.st_en  = 1'b1;
                            o_cmd.st_val = ST_PRESENT;
                            n_state      = S_RES;
                        end else if (i_stat.full) begin
                            o_cmd.st_en  = 1'b1;
                            o_cmd.st_val = ST_FULL;
                            n_state      = S_RES;
                        end else begin
                            o_cmd.ins_start = 1'b1;
                            n_state         = S_UP_CHK;
                        end
                    end
                    OP_REMOVE: begin
                        if (!i_stat.present) begin
                            o_cmd.st_en  = 1'b1;
                            o_cmd.st_val = ST_ABSENT;
                            n_state      = S_RES;
                        end else begin
                            n_state = S_RM_P;
                        end
                    end
                    OP_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.st_en  = 1'b1;
                            o_cmd.st_val = ST_EMPTY;
                            n_state      = S_RES;
                        end else begin
                            o_cmd.hr_en  = 1'b1;
                            o_cmd.hr_sel = HR_ZERO;
                            n_state      = S_POP_H;
                        end
                    end
                    default: n_state = S_RES;
                endcase
            end
            S_RM_P: begin
                if (i_stat.rm_bad) begin
                    o_cmd.st_en  = 1'b1;
                    o_cmd.st_val = ST_ABSENT;
                    n_state      = S_RES;
                end else begin
                    o_cmd.rm_start = 1'b1;
                    if (i_stat.rm_last) begin
                        n_state = S_RES;
                    end else begin
                        o_cmd.hr_en  = 1'b1;
                        o_cmd.hr_sel = HR_CNTM1;
                        n_state      = S_LAST_H;
                    end
                end
            end
            S_POP_H: n_state = S_POP_K;
            S_POP_K: begin
                o_cmd.pop_take = 1'b1;
                if (i_stat.cnt_one) begin
                    n_state = S_RES;
                end else begin
                    o_cmd.hr_en  = 1'b1;
                    o_cmd.hr_sel = HR_CNTM1;
                    n_state      = S_LAST_H;
                end
            end
            S_LAST_H: n_state = S_LAST_K;
            S_LAST_K: begin
                o_cmd.ld_m = 1'b1;
                n_state    = S_DN_L;
            end
            S_DN_L: begin
                if (i_stat.l_ok) begin
                    o_cmd.hr_en  = 1'b1;
                    o_cmd.hr_sel = HR_LEFT;
                    n_state      = S_DN_LH;
                end else begin
                    n_state = S_DN_END;
                end
            end
            S_DN_LH: n_state = S_DN_LK;
            S_DN_LK: begin
                o_cmd.dn_left = 1'b1;
                if (i_stat.r_ok) begin
                    o_cmd.hr_en  = 1'b1;
                    o_cmd.hr_sel = HR_RIGHT;
                    n_state      = S_DN_RH;
                end else begin
                    n_state = S_DN_DEC;
                end
            end
            S_DN_RH: n_state = S_DN_RK;
            S_DN_RK: begin
                o_cmd.dn_right = 1'b1;
                n_state        = S_DN_DEC;
            end
            S_DN_DEC: begin
                if (i_stat.best_same) begin
                    n_state = S_DN_END;
                end else begin
                    o_cmd.dn_step = 1'b1;
                    n_state       = S_DN_L;
                end
            end
            S_DN_END: begin
                if (i_stat.at_start && i_stat.op == OP_REMOVE) begin
                    n_state = S_UP_CHK;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_UP_CHK: begin
                if (i_stat.at_root) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd.hr_en  = 1'b1;
                    o_cmd.hr_sel = HR_UP;
                    n_state      = S_UP_H;
                end
            end
            S_UP_H: n_state = S_UP_K;
            S_UP_K: begin
                if (i_stat.up_lt) begin
                    o_cmd.up_step = 1'b1;
                    n_state       = S_UP_CHK;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_RES;
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/imh_dpath.sv
module imh_dpath #(
    parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [imh_pkg::OP_W-1:0]      i_op,
    input  logic [imh_pkg::HANDLE_W-1:0]  i_handle,
    input  logic [imh_pkg::KEY_W-1:0]     i_key,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [imh_pkg::STATUS_W-1:0]  o_status,
    output logic [imh_pkg::HANDLE_W-1:0]  o_out_handle,
    output logic [imh_pkg::KEY_W-1:0]     o_out_key,
    output logic [imh_pkg::COUNT_W-1:0]   o_count_after,
    input  imh_pkg::t_cmd                 i_cmd,
    output imh_pkg::t_stat                o_stat
);
    import imh_pkg::*;

    `include "indexed_min_heap_assert.svh"

    localparam int LIMIT = (CAPACITY < NUM_HANDLES) ? CAPACITY : NUM_HANDLES;
    localparam int PW    = $clog2(LIMIT);
    localparam int CW    = $clog2(LIMIT + 1);
    localparam int XW    = PW + 2;

    logic [HANDLE_W-1:0] r_heap [LIMIT];
    logic [KEY_BITS-1:0] r_keys [NUM_HANDLES];
    logic [PW-1:0]       r_slot [NUM_HANDLES];
    logic [NUM_HANDLES-1:0] r_vld;

    logic [OP_W-1:0]     r_op;
    logic [HANDLE_W-1:0] r_h;
    logic [KEY_BITS-1:0] r_key;
    logic [CW-1:0]       r_cnt;
    logic [PW-1:0]       r_pos;
    logic [PW-1:0]       r_start;
    logic [HANDLE_W-1:0] r_m;
    logic [KEY_BITS-1:0] r_mk;
    logic [HANDLE_W-1:0] r_bh;
    logic [KEY_BITS-1:0] r_bk;
    logic [PW-1:0]       r_bp;
    logic [HANDLE_W-1:0] r_hq;
    logic [KEY_BITS-1:0] r_kq;
    logic [PW-1:0]       r_pq;
    logic [STATUS_W-1:0] r_st;
    logic [HANDLE_W-1:0] r_oh;
    logic [KEY_BITS-1:0] r_okey;

    logic                r_ovld;
    logic [STATUS_W-1:0] r_o_st;
    logic [HANDLE_W-1:0] r_o_h;
    logic [KEY_BITS-1:0] r_o_k;
    logic [CW-1:0]       r_o_cnt;

    logic [CW-1:0]       cnt_m1;
    logic [XW-1:0]       cnt_x;
    logic [XW-1:0]       left_x;
    logic [XW-1:0]       right_x;
    logic [PW-1:0]       pos_m1;
    logic [PW-1:0]       up_pos;
    logic [PW-1:0]       hr_addr;
    logic                wr_en;
    logic [HANDLE_W-1:0] wr_h;

    assign cnt_m1  = r_cnt - 1'b1;
    assign cnt_x   = XW'(r_cnt);
    assign left_x  = {1'b0, r_pos, 1'b1};
    assign right_x = left_x + 1'b1;
    assign pos_m1  = r_pos - 1'b1;
    assign up_pos  = pos_m1 >> 1;

    always_comb begin
        case (i_cmd.hr_sel)
            HR_ZERO:  hr_addr = '0;
            HR_CNTM1: hr_addr = cnt_m1[PW-1:0];
            HR_UP:    hr_addr = up_pos;
            HR_LEFT:  hr_addr = left_x[PW-1:0];
            HR_RIGHT: hr_addr = right_x[PW-1:0];
            default:  hr_addr = '0;
        endcase
    end

    assign wr_en = i_cmd.dn_step | i_cmd.up_step | i_cmd.place;
    always_comb begin
        if (i_cmd.dn_step) begin
            wr_h = r_bh;
        end else if (i_cmd.up_step) begin
            wr_h = r_hq;
        end else begin
            wr_h = r_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_heap[r_pos] <= wr_h;
            r_slot[wr_h]  <= r_pos;
        end
        if (i_cmd.hr_en) begin
            r_hq <= r_heap[hr_addr];
        end
        if (i_cmd.ins_start) begin
            r_keys[r_h] <= r_key;
        end
        r_kq <= r_keys[r_hq];
        r_pq <= r_slot[r_h];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.rm_start) begin
                r_vld[r_h] <= 1'b0;
                r_cnt      <= cnt_m1;
            end
            if (i_cmd.pop_take) begin
                r_vld[r_hq] <= 1'b0;
                r_cnt       <= cnt_m1;
            end
            if (i_cmd.ins_start) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.place) begin
                r_vld[r_m] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_op   <= i_op;
            r_h    <= i_handle;
            r_key  <= i_key[KEY_BITS-1:0];
            r_st   <= ST_OK;
            r_oh   <= '0;
            r_okey <= '0;
        end
        if (i_cmd.st_en) begin
            r_st <= i_cmd.st_val;
        end
        if (i_cmd.ins_start) begin
            r_m   <= r_h;
            r_mk  <= r_key;
            r_pos <= r_cnt[PW-1:0];
        end
        if (i_cmd.rm_start) begin
            r_pos <= r_pq;
        end
        if (i_cmd.pop_take) begin
            r_oh   <= r_hq;
            r_okey <= r_kq;
            r_pos  <= '0;
        end
        if (i_cmd.ld_m) begin
            r_m     <= r_hq;
            r_mk    <= r_kq;
            r_start <= r_pos;
        end
        if (i_cmd.dn_left) begin
            if (r_kq < r_mk) begin
                r_bh <= r_hq;
                r_bk <= r_kq;
                r_bp <= left_x[PW-1:0];
            end else begin
                r_bh <= r_m;
                r_bk <= r_mk;
                r_bp <= r_pos;
            end
        end
        if (i_cmd.dn_right && r_kq < r_bk) begin
            r_bh <= r_hq;
            r_bk <= r_kq;
            r_bp <= right_x[PW-1:0];
        end
        if (i_cmd.dn_step) begin
            r_pos <= r_bp;
        end
        if (i_cmd.up_step) begin
            r_pos <= up_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovld <= 1'b1;
        end else if (i_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_st  <= r_st;
            r_o_h   <= r_oh;
            r_o_k   <= r_okey;
            r_o_cnt <= r_cnt;
        end
    end

    assign o_valid       = r_ovld;
    assign o_status      = r_o_st;
    assign o_out_handle  = r_o_h;
    assign o_out_key     = KEY_W'(r_o_k);
    assign o_count_after = COUNT_W'(r_o_cnt);

    assign o_stat.op        = r_op;
    assign o_stat.present   = r_vld[r_h];
    assign o_stat.full      = (r_cnt == CW'(LIMIT));
    assign o_stat.empty     = (r_cnt == '0);
    assign o_stat.rm_bad    = (CW'(r_pq) >= r_cnt);
    assign o_stat.rm_last   = (CW'(r_pq) == cnt_m1);
    assign o_stat.cnt_one   = (r_cnt == CW'(1));
    assign o_stat.l_ok      = (left_x < cnt_x);
    assign o_stat.r_ok      = (right_x < cnt_x);
    assign o_stat.best_same = (r_bp == r_pos);
    assign o_stat.at_start  = (r_pos == r_start);
    assign o_stat.at_root   = (r_pos == '0);
    assign o_stat.up_lt     = (r_mk < r_kq);
    assign o_stat.out_free  = !r_ovld || i_ready;

    `IMH_ASSERT_SAME(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(LIMIT), "count above limit")
    `IMH_ASSERT_NEXT(a_ins_grow, i_clk, i_rst_n, i_cmd.ins_start, r_cnt == $past(r_cnt) + 1'b1, "insert did not grow count")
    `IMH_ASSERT_SAME(a_wr_in_range, i_clk, i_rst_n, wr_en, CW'(r_pos) < r_cnt, "heap write beyond count")

endmodule

### rtl/indexed_min_heap.sv
// Channel  | Handshake          | Beat contents
// ---------+--------------------+----------------------------------------
// input    | i_valid / o_ready  | i_op, i_handle, i_key
// output   | o_valid / i_ready  | o_status, o_out_handle, o_out_key, o_count_after
//
// One item at a time; a rejected or trivial item skips the sift.
// A sift makes a dependent heap-slot read and then a key read at each level,
// of the parent going up, and of the left and, if present, right child going down.
// Reset clears the presence bits and the count directly; no clearing pass.
// A new beat is taken while the previous result waits in the output register.
// A stalled output holds the finished item in its last state until it drains.
module indexed_min_heap #(
    parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [imh_pkg::OP_W-1:0]      i_op,
    input  logic [imh_pkg::HANDLE_W-1:0]  i_handle,
    input  logic [imh_pkg::KEY_W-1:0]     i_key,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [imh_pkg::STATUS_W-1:0]  o_status,
    output logic [imh_pkg::HANDLE_W-1:0]  o_out_handle,
    output logic [imh_pkg::KEY_W-1:0]     o_out_key,
    output logic [imh_pkg::COUNT_W-1:0]   o_count_after
);
    import imh_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    imh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    imh_dpath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_op),
        .i_handle      (i_handle),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_out_handle  (o_out_handle),
        .o_out_key     (o_out_key),
        .o_count_after (o_count_after),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

endmodule
